// ===== hdl/stpt_pkg.sv =====
// Shared widths, register map and saturation helper for the staging-to-position
// transform. No dependencies; imported by stpt_divider and the top level.
`default_nettype none

package stpt_pkg;

    localparam int Q_W           = 32;          // Q16.16 sample width
    localparam int ACC_W         = 48;          // intermediate accumulator width
    localparam int SUM_W         = ACC_W + 1;   // accumulator plus one stage sample
    localparam int CNT_W         = 7;           // bead count / bead index width
    localparam int MAX_BEADS_DEF = 64;
    localparam int ADDR_W        = 3;           // APB byte address width
    localparam int REG_IDX_W     = ADDR_W - 2;

    localparam logic [CNT_W-1:0]     MIN_BEADS      = 7'd2;
    localparam logic [CNT_W-1:0]     BEAD_COUNT_RST = 7'd2;
    localparam logic [REG_IDX_W-1:0] REG_BEAD_COUNT = 1'b0;

    // Clamp a wide signed sum to the signed Q16.16 range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v[SUM_W-1:Q_W-1] == {(SUM_W-Q_W+1){v[SUM_W-1]}}) begin
            r = v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/stpt_divider.sv =====
// Restoring divider: signed 48-bit dividend by unsigned bead index, one
// quotient bit per cycle, truncating toward zero. Depends on stpt_pkg.
`default_nettype none

module stpt_divider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [stpt_pkg::ACC_W-1:0]   dividend,
    input  logic        [stpt_pkg::CNT_W-1:0]   divisor,
    output logic                                done,
    output logic signed [stpt_pkg::ACC_W-1:0]   quotient
);
    import stpt_pkg::*;

    localparam int DCNT_W = $clog2(ACC_W + 1);
    localparam logic [DCNT_W-1:0] STEPS = DCNT_W'(ACC_W);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              neg_reg;
    logic [ACC_W-1:0]  mag_reg;      // dividend magnitude, quotient bits shift in
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic signed [ACC_W-1:0] quo_reg;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, mag_reg[ACC_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEPS;
            end else if (busy_reg && cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end else if (busy_reg) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[ACC_W-1];
            mag_reg <= dividend[ACC_W-1] ? -dividend : dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg && cnt_reg != '0) begin
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            mag_reg <= {mag_reg[ACC_W-2:0], ge};
        end else if (busy_reg) begin
            quo_reg <= neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/staging_to_position_transform.sv =====
// Staging-to-position transform for a closed bead chain: sequencer, stores
// and APB register. Depends on stpt_pkg and stpt_divider.
//
// Usage:
//  - s_ channel: one staging coordinate u[k] (signed Q16.16) per beat, in bead
//    order. s_tready is high only while coordinates are being collected.
//  - m_ channel: n bead positions r[1..n] per chain, in index order; tlast
//    marks r[n]. Positions saturate to the Q16.16 range.
//  - APB: bead_count (7 bits) at byte address 0. Values below 2 act as 2,
//    values above MAX_BEADS as MAX_BEADS. A write drops a partly loaded chain.
//    Write only while the block is idle.
// Timing:
//  - Collecting takes one coordinate beat per cycle.
//  - After the n-th beat: r[n] is formed first, then each of r[n-1] down to
//    r[2] takes a multiply-add step, a divider start, 48 steps of the shared
//    restoring divider and its sign fix-up. The divider sets the rate.
//  - Output: each beat is a position store read, then a load of the output
//    register. A stalled receiver simply holds the sequencer; nothing is
//    dropped. Once r[n] sits in the output register, the next chain's
//    coordinates are taken.
//  - Reset (aresetn low, synchronous): bead_count back to 2, the partial chain
//    and any pending output beat are dropped. Stores need no clearing.
`default_nettype none

module staging_to_position_transform #(
    parameter int MAX_BEADS = stpt_pkg::MAX_BEADS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: [31:0] stage_value
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,
    // m_tdata: [31:0] position; m_tlast: last_bead
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stpt_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import stpt_pkg::*;

    localparam int AW = $clog2(MAX_BEADS);

    // sequencer states
    localparam logic [2:0] S_LOAD     = 3'd0;  // collecting coordinates
    localparam logic [2:0] S_TAIL     = 3'd1;  // r[n] = u[n] + r1
    localparam logic [2:0] S_MUL      = 3'd2;  // acc = (i-1)*r[i+1] + r1, fetch u[i]
    localparam logic [2:0] S_DIV_GO   = 3'd3;  // kick the divider
    localparam logic [2:0] S_DIV_WAIT = 3'd4;  // wait for quotient, store r[i]
    localparam logic [2:0] S_OUT_RD   = 3'd5;  // read position store
    localparam logic [2:0] S_OUT_WR   = 3'd6;  // load output register

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        bead_count_reg, bead_count_next;
    logic [CNT_W-1:0]        load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;        // loop index i (model's 0-based store index)
    logic [CNT_W-1:0]        out_idx_reg, out_idx_next;
    logic signed [Q_W-1:0]   first_reg, first_next;    // r1 of current chain
    logic signed [Q_W-1:0]   last_u_reg, last_u_next;  // most recent coordinate beat
    logic signed [Q_W-1:0]   prev_reg, prev_next;      // r[i+1], last position computed
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    m_tlast_reg, m_tlast_next;
    logic [Q_W-1:0]          m_tdata_reg, m_tdata_next;

    // stores
    logic [Q_W-1:0]          stage_mem [MAX_BEADS];
    logic [Q_W-1:0]          pos_mem   [MAX_BEADS];
    logic signed [Q_W-1:0]   stage_rd_reg;
    logic [Q_W-1:0]          pos_rd_reg;
    logic                    stage_we, stage_re, pos_we, pos_re;
    logic [AW-1:0]           stage_waddr, stage_raddr, pos_waddr, pos_raddr;
    logic [Q_W-1:0]          pos_wdata;

    // datapath
    logic [CNT_W-1:0]        chain_len;
    logic [CNT_W-1:0]        idx_m1;
    logic signed [Q_W+CNT_W:0] prod;
    logic signed [Q_W-1:0]   tail_pos;
    logic signed [Q_W-1:0]   div_pos;
    logic                    div_start;
    logic                    div_done;
    logic signed [ACC_W-1:0] div_quo;

    logic                    s_accept;
    logic                    cfg_wr;
    logic                    cfg_hit;

    // effective chain length: clamp to [2, MAX_BEADS]
    always_comb begin
        if (bead_count_reg < MIN_BEADS) begin
            chain_len = MIN_BEADS;
        end else if (int'(bead_count_reg) > MAX_BEADS) begin
            chain_len = CNT_W'(MAX_BEADS);
        end else begin
            chain_len = bead_count_reg;
        end
    end

    assign s_tready = (state_reg == S_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_hit  = (paddr[ADDR_W-1:2] == REG_BEAD_COUNT);
    assign cfg_wr   = psel && penable && pwrite && pready && cfg_hit;
    assign pready   = 1'b1;
    assign prdata   = cfg_hit ? 32'(bead_count_reg) : '0;

    assign idx_m1   = idx_reg - 1'b1;
    // (i-1) * r[i+1]: 8x32 signed, at most ~38 significant bits
    assign prod     = $signed({1'b0, idx_m1}) * prev_reg;
    assign tail_pos = sat_q(SUM_W'(last_u_reg) + SUM_W'(first_reg));
    assign div_pos  = sat_q(SUM_W'(stage_rd_reg) + SUM_W'(div_quo));

    stpt_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (idx_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next      = state_reg;
        bead_count_next = bead_count_reg;
        load_cnt_next   = load_cnt_reg;
        idx_next        = idx_reg;
        out_idx_next    = out_idx_reg;
        first_next      = first_reg;
        last_u_next     = last_u_reg;
        prev_next       = prev_reg;
        acc_next        = acc_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        stage_we        = 1'b0;
        stage_re        = 1'b0;
        pos_we          = 1'b0;
        pos_re          = 1'b0;
        stage_waddr     = AW'(load_cnt_reg);
        stage_raddr     = AW'(idx_m1);
        pos_waddr       = AW'(idx_m1);
        pos_raddr       = AW'(out_idx_reg);
        pos_wdata       = div_pos;
        div_start       = 1'b0;

        unique case (state_reg)
            S_LOAD: begin
                if (s_accept) begin
                    stage_we    = 1'b1;
                    last_u_next = s_tdata;
                    if (load_cnt_reg == '0) begin
                        // r1 = u1 goes straight to the position store
                        first_next = s_tdata;
                        pos_we     = 1'b1;
                        pos_waddr  = '0;
                        pos_wdata  = s_tdata;
                    end
                    if (load_cnt_reg == chain_len - 1'b1) begin
                        load_cnt_next = '0;
                        state_next    = S_TAIL;
                    end else begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
                if (cfg_wr) begin
                    bead_count_next = pwdata[CNT_W-1:0];
                    load_cnt_next   = '0;
                end
            end
            S_TAIL: begin
                pos_we    = 1'b1;
                pos_waddr = AW'(chain_len - 1'b1);
                pos_wdata = tail_pos;
                prev_next = tail_pos;
                idx_next  = chain_len - 1'b1;
                if (chain_len == MIN_BEADS) begin
                    out_idx_next = '0;
                    state_next   = S_OUT_RD;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                acc_next   = ACC_W'(prod) + ACC_W'(first_reg);
                stage_re   = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    pos_we    = 1'b1;
                    prev_next = div_pos;
                    if (idx_reg == MIN_BEADS) begin
                        out_idx_next = '0;
                        state_next   = S_OUT_RD;
                    end else begin
                        idx_next   = idx_m1;
                        state_next = S_MUL;
                    end
                end
            end
            S_OUT_RD: begin
                pos_re     = 1'b1;
                state_next = S_OUT_WR;
            end
            S_OUT_WR: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pos_rd_reg;
                    m_tlast_next  = (out_idx_reg == chain_len - 1'b1);
                    if (out_idx_reg == chain_len - 1'b1) begin
                        state_next = S_LOAD;
                    end else begin
                        out_idx_next = out_idx_reg + 1'b1;
                        state_next   = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            bead_count_reg <= BEAD_COUNT_RST;
            load_cnt_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            bead_count_reg <= bead_count_next;
            load_cnt_reg   <= load_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        out_idx_reg <= out_idx_next;
        first_reg   <= first_next;
        last_u_reg  <= last_u_next;
        prev_reg    <= prev_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // stage store: written while loading, read during the backward pass
    always_ff @(posedge aclk) begin
        if (stage_we) begin
            stage_mem[stage_waddr] <= s_tdata;
        end
        if (stage_re) begin
            stage_rd_reg <= stage_mem[stage_raddr];
        end
    end

    // position store: written by the backward pass, read for output
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (pos_re) begin
            pos_rd_reg <= pos_mem[pos_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    a_load_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        load_cnt_reg < chain_len)
        else $error("load count reached chain length");

    a_out_load_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT_WR))
        else $error("output beat raised outside output load state");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished while sequencer not waiting");

    a_loop_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (idx_reg >= MIN_BEADS && idx_reg < chain_len))
        else $error("backward pass index out of range");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for staging_to_position_transform: streams staging coordinates,
// predicts bead positions, checks every m_ beat and the APB register readback.
// Depends on stpt_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;
    import stpt_pkg::*;

    localparam int CHAIN_MAX     = MAX_BEADS_DEF;
    localparam int LIMIT_CYCLES  = 5000000; // far above the slowest legal run
    localparam int SETTLE_CYCLES = 20;      // settle time after the last position arrives
    localparam int DRAIN_CYCLES  = 60;      // tail after the last position
    localparam int HOLD_AT       = 24;      // positions seen before the long hold
    localparam int HOLD_CYCLES   = 400;
    localparam int RAND_BEATS    = 220;
    localparam int MAX_REPORTS   = 10;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;  // decodes to nothing

    typedef enum logic [1:0] {
        ROW_BEAT,        // one staging coordinate
        ROW_SET_COUNT,   // write bead_count
        ROW_SET_UNUSED   // write the unmapped register
    } row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [31:0] value;
        logic        typed;       // expected r1/r2 given below (n = 2 chains only)
        logic [31:0] exp_first;
        logic [31:0] exp_second;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] position;
        logic        last_bead;
    } bead_pos_t;

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;     // [31:0] stage_value
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;           // [31:0] position
    logic              m_tlast;           // last_bead
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    staging_to_position_transform u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Position predictor: own copy of the chain stores and bead_count
    // ------------------------------------------------------------------
    logic signed [31:0] stage_mem [CHAIN_MAX];
    logic signed [31:0] pos_mem   [CHAIN_MAX];
    int unsigned        fill_cnt = 0;
    logic [CNT_W-1:0]   bead_cfg = BEAD_COUNT_RST;
    bead_pos_t          bead_positions_q [$];

    int err_cnt   = 0;
    int got_cnt   = 0;
    int cycle_cnt = 0;
    int burst_left = 0;

    function automatic int unsigned chain_len();
        if (bead_cfg < MIN_BEADS) return int'(MIN_BEADS);
        if (bead_cfg > CHAIN_MAX) return CHAIN_MAX;
        return int'(bead_cfg);
    endfunction

    function automatic logic signed [31:0] clamp_q(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Store one coordinate; on the n-th, queue r[1..n] in output order.
    task automatic predict_positions(logic signed [31:0] u);
        int unsigned        n;
        int                 i;
        longint             acc;
        longint             quo;
        logic signed [31:0] r1;
        n = chain_len();
        if (fill_cnt >= n) fill_cnt = 0;
        stage_mem[fill_cnt] = u;
        fill_cnt++;
        if (fill_cnt < n) return;
        fill_cnt = 0;
        r1 = stage_mem[0];
        pos_mem[0] = r1;
        pos_mem[n-1] = clamp_q(longint'(stage_mem[n-1]) + longint'(r1));
        // back substitution, each term reusing the saturated r[i+1]
        for (i = n - 1; i >= 2; i--) begin
            acc = longint'(i - 1) * longint'(pos_mem[i]) + longint'(r1);
            quo = acc / longint'(i);   // truncates toward zero
            pos_mem[i-1] = clamp_q(longint'(stage_mem[i-1]) + quo);
        end
        for (i = 0; i < n; i++)
            bead_positions_q.push_back('{position: pos_mem[i], last_bead: (i == n - 1)});
    endtask

    task automatic flag_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
    endtask

    // ------------------------------------------------------------------
    // m_ side checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bead_pos_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got_cnt <= got_cnt + 1;
            if (bead_positions_q.size() == 0) begin
                flag_mismatch("unexpected position beat", '0, m_tdata);
            end else begin
                want = bead_positions_q.pop_front();
                if (m_tdata !== want.position)
                    flag_mismatch("position", want.position, m_tdata);
                if (m_tlast !== want.last_bead)
                    flag_mismatch("last_bead", {31'b0, want.last_bead}, {31'b0, m_tlast});
            end
        end
    end

    // ------------------------------------------------------------------
    // m_ side backpressure: rotating stall pattern, reloaded now and then
    // (a third of the reloads are all-ready), plus one long hold that lets
    // the sequencer back up and close s_tready while the sender keeps offering.
    // ------------------------------------------------------------------
    logic [15:0] rx_pat    = 16'hFFFF;
    int          rx_left   = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && m_tvalid && got_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (rx_left == 0) begin
            rx_left  <= $urandom_range(20, 200);
            rx_pat   <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                    : (16'($urandom) | 16'h0101);
            m_tready <= 1'b1;
        end else begin
            rx_left  <= rx_left - 1;
            rx_pat   <= {rx_pat[0], rx_pat[15:1]};
            m_tready <= rx_pat[0];
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers; every task is entered and left on a rising-edge time step
    // ------------------------------------------------------------------

    // One s_ beat; bursts of random length with random gaps between them.
    task automatic send_stage(logic [31:0] u);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= u;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        predict_positions(u);
    endtask

    // Drop valid, let every queued position arrive, then let the block settle.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (bead_positions_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_cycle(logic wr, logic [REG_IDX_W-1:0] idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read bead_count back and compare with the predictor's copy.
    task automatic check_bead_count();
        logic [31:0] rd;
        apb_cycle(1'b0, REG_BEAD_COUNT, '0, rd);
        if (rd !== {25'b0, bead_cfg})
            flag_mismatch("bead_count readback", {25'b0, bead_cfg}, rd);
    endtask

    task automatic set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        logic [31:0] rd;
        wait_quiet();
        apb_cycle(1'b1, idx, value, rd);
        if (idx == REG_BEAD_COUNT) begin
            bead_cfg = value[CNT_W-1:0];
            fill_cnt = 0;   // a write drops the partial chain
        end
        @(posedge aclk);    // idle bus before the readback
        check_bead_count();
    endtask

    // Mix of full-range, small, near-rail and scaled coordinates.
    function automatic logic [31:0] pick_stage();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            2: return $urandom_range(0, 1) ? (32'h7FFF_0000 | $urandom_range(0, 16'hFFFF))
                                           : (32'h8000_0000 | $urandom_range(0, 16'hFFFF));
            default: return $signed($urandom) >>> $urandom_range(0, 16);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed rows. Typed expectations only for n = 2 chains, where
    // r1 = u1 and r2 = sat(u1 + u2).
    // ------------------------------------------------------------------
    stim_row_t dir_rows [29] = '{
        // rails: saturate high, saturate low, opposite rails cancel to -1 lsb
        '{ROW_BEAT,       32'h7FFF_FFFF, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF,  32'h7FFF_FFFF},
        '{ROW_BEAT,       32'h8000_0000, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h8000_0000, 1'b1, 32'h8000_0000,  32'h8000_0000},
        '{ROW_BEAT,       32'h7FFF_FFFF, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h8000_0000, 1'b1, 32'h7FFF_FFFF,  32'hFFFF_FFFF},
        '{ROW_BEAT,       32'h0000_0000, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h0000_0000, 1'b1, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h0001_0000, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'hFFFF_0000, 1'b1, 32'h0001_0000,  32'h0},
        // bead_count 0 and 1 behave as 2
        '{ROW_SET_COUNT,  32'd0,         1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h1234_5678, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h0000_0001, 1'b1, 32'h1234_5678,  32'h1234_5679},
        '{ROW_SET_COUNT,  32'd1,         1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'hFFFF_FFFF, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFE},
        // partial chain dropped by a rewrite of bead_count
        '{ROW_SET_COUNT,  32'd3,         1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h0003_0000, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h0005_0000, 1'b0, 32'h0,          32'h0},
        '{ROW_SET_COUNT,  32'd3,         1'b0, 32'h0,          32'h0},
        // unmapped register write mid-chain must keep the partial chain
        '{ROW_BEAT,       32'h0001_0000, 1'b0, 32'h0,          32'h0},
        '{ROW_SET_UNUSED, 32'd5,         1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h0002_0000, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h0003_0000, 1'b0, 32'h0,          32'h0},
        // n = 4 with alternating rails through the divider path
        '{ROW_SET_COUNT,  32'd4,         1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h8000_0000, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h7FFF_FFFF, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h8000_0000, 1'b0, 32'h0,          32'h0},
        '{ROW_BEAT,       32'h7FFF_FFFF, 1'b0, 32'h0,          32'h0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int               r;
        int               phase;
        int               rand_beats;
        int               chains;
        int               n_eff;
        int               k;
        int               tail;
        int               pick;
        logic [CNT_W-1:0] cnt_val;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_bead_count();   // reset value

        for (r = 0; r < $size(dir_rows); r++) begin
            case (dir_rows[r].kind)
                ROW_SET_COUNT: begin
                    set_register(REG_BEAD_COUNT, dir_rows[r].value);
                end
                ROW_SET_UNUSED: begin
                    set_register(REG_UNUSED, dir_rows[r].value);
                end
                default: begin
                    send_stage(dir_rows[r].value);
                    if (dir_rows[r].typed) begin
                        bead_positions_q[bead_positions_q.size() - 2].position =
                            dir_rows[r].exp_first;
                        bead_positions_q[bead_positions_q.size() - 1].position =
                            dir_rows[r].exp_second;
                    end
                end
            endcase
        end

        // Random phases. Phase 0 is a run of short chains that the long
        // hold lands on; phases 3 and 6 take the 64-bead extremes, one
        // chain each; the rest stay small, some with a dropped tail.
        phase      = 0;
        rand_beats = 0;
        while (rand_beats < RAND_BEATS || phase <= 6) begin
            if (phase == 0) begin
                cnt_val = 7'd3;
            end else if (phase == 3) begin
                cnt_val = CNT_W'(CHAIN_MAX);
            end else if (phase == 6) begin
                cnt_val = 7'd127;
            end else begin
                pick = $urandom_range(0, 15);
                if (pick == 0)      cnt_val = CNT_W'($urandom_range(0, 1));
                else if (pick == 1) cnt_val = CNT_W'($urandom_range(9, 20));
                else                cnt_val = CNT_W'($urandom_range(2, 8));
            end
            set_register(REG_BEAD_COUNT, {25'b0, cnt_val});
            n_eff  = chain_len();
            chains = (phase == 0) ? 4 : (n_eff > 20) ? 1 : $urandom_range(1, 4);
            for (k = 0; k < chains * n_eff; k++) begin
                send_stage(pick_stage());
                rand_beats++;
            end
            // broken chain: left partial, dropped by the next write
            if (n_eff <= 20 && $urandom_range(0, 3) == 0) begin
                tail = $urandom_range(1, n_eff - 1);
                for (k = 0; k < tail; k++) begin
                    send_stage(pick_stage());
                    rand_beats++;
                end
            end
            phase++;
        end

        // drain
        s_tvalid <= 1'b0;
        while (bead_positions_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        err_cnt += bead_positions_q.size();

        if (err_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
